[hdl/det_pkg.sv]
// ----------------------------------------------------------------------------
// det_pkg
// shared types and constants of the directional edge threshold block
// ----------------------------------------------------------------------------
package det_pkg;

  localparam int PIXEL_W  = 8;
  localparam int ACTION_W = 1;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_PIXEL = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_FLUSH = 1'b1;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAY_MODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd4;

  localparam int HALF_WINDOW_W  = 2;
  localparam int THRESHOLD_W    = 8;
  localparam int IMAGE_WIDTH_W  = 11;
  localparam int IMAGE_HEIGHT_W = 13;

  localparam logic [HALF_WINDOW_W-1:0]  RST_HALF_WINDOW    = 2'd1;
  localparam logic [THRESHOLD_W-1:0]    RST_EDGE_THRESHOLD = 8'd128;
  localparam logic                      RST_OVERLAY_MODE   = 1'b0;
  localparam logic [IMAGE_WIDTH_W-1:0]  RST_IMAGE_WIDTH    = 11'd640;
  localparam logic [IMAGE_HEIGHT_W-1:0] RST_IMAGE_HEIGHT   = 13'd480;

  localparam logic [PIXEL_W-1:0] PIX_WHITE = 8'hFF;
  localparam logic [PIXEL_W-1:0] PIX_BLACK = 8'h00;

endpackage

[hdl/det_if.sv]
// ----------------------------------------------------------------------------
// det stream interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface det_in_if;
  logic                          valid;
  logic                          ready;
  logic [det_pkg::ACTION_W-1:0]  action;
  logic [det_pkg::PIXEL_W-1:0]   pixel_in;

  modport source (output valid, output action, output pixel_in, input ready);
  modport sink   (input valid, input action, input pixel_in, output ready);
endinterface

interface det_out_if;
  logic                          valid;
  logic                          ready;
  logic [det_pkg::PIXEL_W-1:0]   pixel_out;
  logic                          frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

[hdl/directional_edge_threshold.sv]
// ----------------------------------------------------------------------------
// directional_edge_threshold
// four-direction windowed edge detector on a raster grey pixel stream
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries items in raster order: action pixel carries the next pixel,
//   action flush drains the outputs still owed once the frame input is done.
//   out_ch carries one item per output raster position: 255 on an edge,
//   the input pixel (overlay on) or 0 otherwise, 0 on the border ring.
//   frame_last marks the last position of the image.
//   configuration is written through cfg_we/cfg_index/cfg_data while idle;
//   a geometry write restarts the frame.
// throughput and order:
//   one item per clock while out_ch is ready. an output item is registered
//   through stages 1 to 4; outputs trail the input by n rows plus n pixels.
//   the line store is one column-wide memory (all stored rows of a column
//   in one word), read once and written once per pixel item, which sets
//   the rate of one pixel per clock.
// reset and stall:
//   rst clears counters and pipeline valids and loads the register defaults.
//   the line store is not cleared. when out_ch stalls, the pipeline
//   keeps taking items until its four stages are full, then drops ready.
// ----------------------------------------------------------------------------
module directional_edge_threshold #(
  parameter int MAX_RADIUS = 3,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  det_in_if.sink                          in_ch,
  det_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [det_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [det_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int S    = 2 * MAX_RADIUS + 1;           // stored rows, window side
  localparam int SLW  = $clog2(S);
  localparam int NW   = $clog2(MAX_RADIUS + 1);
  localparam int CI   = $clog2(MAX_WIDTH);            // column index
  localparam int CWW  = $clog2(MAX_WIDTH + 1);        // width value
  localparam int RW   = $clog2(MAX_HEIGHT + 1);       // row counter / height
  localparam int PW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int KMAX = MAX_RADIUS * S;
  localparam int KW   = $clog2(KMAX + 1);
  localparam int SW   = $clog2(KMAX * 255 + 1) + 1;   // signed direction sum
  localparam int TKW  = det_pkg::THRESHOLD_W + KW;
  localparam int CMW  = (SW > TKW) ? SW : TKW;
  localparam int TN   = 1 << $clog2(S * S);           // adder tree leaves

  localparam int PXW = det_pkg::PIXEL_W;

  // configuration registers
  logic [det_pkg::HALF_WINDOW_W-1:0]  half_window;
  logic [det_pkg::THRESHOLD_W-1:0]    edge_threshold;
  logic                               overlay_mode;
  logic [det_pkg::IMAGE_WIDTH_W-1:0]  image_width;
  logic [det_pkg::IMAGE_HEIGHT_W-1:0] image_height;
  logic                               geom_wr;

  // effective geometry after clamping
  logic [NW-1:0]  n_eff;
  logic [CWW-1:0] w_eff;
  logic [RW-1:0]  h_eff;
  logic [PW-1:0]  delay;

  // raster counters
  logic [RW-1:0]  in_row, in_row_next;
  logic [CI-1:0]  in_col, in_col_next;
  logic [RW-1:0]  out_row, out_row_next;
  logic [CI-1:0]  out_col, out_col_next;
  logic [SLW-1:0] slot, slot_next;
  logic [PW-1:0]  pending, pending_next;

  // item decode at the input
  logic in_fire, pix_item, emit_now, border_now, last_now;

  // pipeline enables
  logic en1, en2, en3, en4;

  // stage 1: line store read
  logic           v1, s1_shift, s1_emit, s1_border, s1_last;
  logic [PXW-1:0] s1_pixel;
  logic [CI-1:0]  s1_col;
  logic [SLW-1:0] s1_slot;
  logic [S-1:0][PXW-1:0] rdata;
  logic [S-1:0][PXW-1:0] line_store [MAX_WIDTH];
  logic [S-1:0][PXW-1:0] wb_word;
  logic [S-1:0][PXW-1:0] col_vec;
  logic           wr_en;

  // stage 2: window
  logic           v2, s2_emit, s2_border, s2_last;
  logic [PXW-1:0] win [S][S];                          // [column age][row age]
  logic signed [SW-1:0] dg_sum, vt_sum, ad_sum, hz_sum;
  logic [PXW-1:0] centre;

  // stage 3: direction differences
  logic           v3, s3_border, s3_last;
  logic signed [SW-1:0] s3_dg, s3_vt, s3_ad, s3_hz;
  logic [PXW-1:0] s3_centre;

  // stage 4: output register
  logic           v4;
  logic [PXW-1:0] pixel_out;
  logic           frame_last;
  logic [SW-1:0]  best;
  logic [TKW-1:0] thr_k;
  logic           is_edge;
  logic [PXW-1:0] pix_res;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      half_window    <= det_pkg::RST_HALF_WINDOW;
      edge_threshold <= det_pkg::RST_EDGE_THRESHOLD;
      overlay_mode   <= det_pkg::RST_OVERLAY_MODE;
      image_width    <= det_pkg::RST_IMAGE_WIDTH;
      image_height   <= det_pkg::RST_IMAGE_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        det_pkg::REG_HALF_WINDOW:
          half_window <= cfg_data[det_pkg::HALF_WINDOW_W-1:0];
        det_pkg::REG_EDGE_THRESHOLD:
          edge_threshold <= cfg_data[det_pkg::THRESHOLD_W-1:0];
        det_pkg::REG_OVERLAY_MODE:
          overlay_mode <= cfg_data[0];
        det_pkg::REG_IMAGE_WIDTH:
          image_width <= cfg_data[det_pkg::IMAGE_WIDTH_W-1:0];
        det_pkg::REG_IMAGE_HEIGHT:
          image_height <= cfg_data[det_pkg::IMAGE_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // a geometry write abandons the frame in flight
  assign geom_wr = cfg_we && (cfg_index == det_pkg::REG_HALF_WINDOW ||
                              cfg_index == det_pkg::REG_IMAGE_WIDTH ||
                              cfg_index == det_pkg::REG_IMAGE_HEIGHT);

  // clamp the geometry registers into the supported range
  always_comb begin
    if (half_window == '0)                n_eff = NW'(1);
    else if (int'(half_window) > MAX_RADIUS) n_eff = NW'(MAX_RADIUS);
    else                                  n_eff = NW'(half_window);

    if (image_width == '0)                w_eff = CWW'(1);
    else if (int'(image_width) > MAX_WIDTH) w_eff = CWW'(MAX_WIDTH);
    else                                  w_eff = CWW'(image_width);

    if (image_height == '0)               h_eff = RW'(1);
    else if (int'(image_height) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
    else                                  h_eff = RW'(image_height);
  end

  // outputs trail the input by n rows plus n pixels
  assign delay = PW'(n_eff) * PW'(w_eff) + PW'(n_eff);

  // --------------------------------------------------------------------------
  // input decode and raster counters
  // --------------------------------------------------------------------------
  assign in_ch.ready = en1;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // a pixel after the frame input is complete is dropped and drains instead
  assign pix_item = (in_ch.action == det_pkg::ACT_PIXEL) && (in_row < h_eff);
  assign emit_now = pix_item ? ((pending + PW'(1)) > delay) : (in_row >= h_eff);

  // pixels closer than n to any image edge always give 0
  assign border_now = (out_row < RW'(n_eff)) ||
                      ((RW+1)'(out_row) + (RW+1)'(n_eff) >= (RW+1)'(h_eff)) ||
                      (CWW'(out_col) < CWW'(n_eff)) ||
                      ((CWW+1)'(out_col) + (CWW+1)'(n_eff) >= (CWW+1)'(w_eff));
  assign last_now = (out_row == h_eff - RW'(1)) && (CWW'(out_col) == w_eff - CWW'(1));

  always_comb begin
    in_row_next  = in_row;
    in_col_next  = in_col;
    out_row_next = out_row;
    out_col_next = out_col;
    slot_next    = slot;
    pending_next = pending;
    if (geom_wr) begin
      in_row_next  = '0;
      in_col_next  = '0;
      out_row_next = '0;
      out_col_next = '0;
      slot_next    = '0;
      pending_next = '0;
    end else if (in_fire) begin
      if (pix_item) begin
        if (CWW'(in_col) + CWW'(1) >= w_eff) begin
          in_col_next = '0;
          in_row_next = in_row + RW'(1);
          slot_next   = (slot == SLW'(S - 1)) ? '0 : slot + SLW'(1);
        end else begin
          in_col_next = in_col + CI'(1);
        end
        if (!emit_now) pending_next = pending + PW'(1);
      end else if (emit_now) begin
        pending_next = pending - PW'(1);
      end
      if (emit_now) begin
        if (CWW'(out_col) + CWW'(1) >= w_eff) begin
          out_col_next = '0;
          out_row_next = out_row + RW'(1);
        end else begin
          out_col_next = out_col + CI'(1);
        end
        // frame end: everything restarts at the origin
        if (last_now) begin
          in_row_next  = '0;
          in_col_next  = '0;
          out_row_next = '0;
          out_col_next = '0;
          slot_next    = '0;
          pending_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
      slot    <= '0;
      pending <= '0;
    end else begin
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
      slot    <= slot_next;
      pending <= pending_next;
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control: each stage moves when the one after it has room
  // --------------------------------------------------------------------------
  assign en4 = !v4 || out_ch.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  // --------------------------------------------------------------------------
  // stage 1: line store read-modify-write, one column word per pixel
  // --------------------------------------------------------------------------
  assign wr_en = v1 && s1_shift && en2;

  always_comb begin
    int age;
    wb_word = rdata;
    wb_word[s1_slot] = s1_pixel;
    // column ordered by row age, newest row first
    for (int k = 0; k < S; k++) begin
      age = int'(s1_slot) - k;
      if (age < 0) age = age + S;
      col_vec[k] = (k == 0) ? s1_pixel : rdata[SLW'(age)];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) line_store[s1_col] <= wb_word;
  end

  // read port, forwarding the word being written back on the same column
  always_ff @(posedge clk) begin
    if (in_fire && pix_item) begin
      if (wr_en && s1_col == in_col) rdata <= wb_word;
      else                           rdata <= line_store[in_col];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || geom_wr) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_fire && (pix_item || emit_now);
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_fire) begin
      s1_shift  <= pix_item;
      s1_emit   <= emit_now;
      s1_border <= border_now;
      s1_last   <= last_now;
      s1_pixel  <= in_ch.pixel_in;
      s1_col    <= in_col;
      s1_slot   <= slot;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: square window, one column shifted in per pixel
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en2 && v1 && s1_shift) begin
      for (int c = S - 1; c > 0; c--) win[c] <= win[c-1];
      for (int k = 0; k < S; k++) win[0][k] <= col_vec[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || geom_wr) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1 && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      s2_emit   <= s1_emit;
      s2_border <= s1_border;
      s2_last   <= s1_last;
    end
  end

  // half-window sums on either side of the four lines through the centre;
  // i counts rows from the top, j columns from the left of the window.
  // every cell gives +v, -v or 0 per direction, then a balanced adder tree
  always_comb begin
    int nn, ii, jj, e;
    logic signed [SW-1:0] v;
    logic signed [SW-1:0] t_dg [TN];
    logic signed [SW-1:0] t_vt [TN];
    logic signed [SW-1:0] t_ad [TN];
    logic signed [SW-1:0] t_hz [TN];
    nn = int'(n_eff);
    for (int x = 0; x < TN; x++) begin
      t_dg[x] = '0;
      t_vt[x] = '0;
      t_ad[x] = '0;
      t_hz[x] = '0;
    end
    for (int c = 0; c < S; c++) begin
      for (int k = 0; k < S; k++) begin
        e  = c * S + k;
        ii = 2 * nn - k;
        jj = 2 * nn - c;
        v  = SW'(win[c][k]);
        if (ii >= 0 && jj >= 0) begin
          if (jj > ii) t_dg[e] = v;
          else if (jj < ii) t_dg[e] = -v;
          if (jj > nn) t_vt[e] = v;
          else if (jj < nn) t_vt[e] = -v;
          if (ii + jj > 2 * nn) t_ad[e] = v;
          else if (ii + jj < 2 * nn) t_ad[e] = -v;
          if (ii < nn) t_hz[e] = v;
          else if (ii > nn) t_hz[e] = -v;
        end
      end
    end
    // pairwise reduction, log2(TN) adders deep
    for (int step = 1; step < TN; step = step * 2) begin
      for (int x = 0; x + step < TN; x = x + 2 * step) begin
        t_dg[x] = t_dg[x] + t_dg[x+step];
        t_vt[x] = t_vt[x] + t_vt[x+step];
        t_ad[x] = t_ad[x] + t_ad[x+step];
        t_hz[x] = t_hz[x] + t_hz[x+step];
      end
    end
    dg_sum = t_dg[0];
    vt_sum = t_vt[0];
    ad_sum = t_ad[0];
    hz_sum = t_hz[0];
  end

  assign centre = win[SLW'(n_eff)][SLW'(n_eff)];

  // --------------------------------------------------------------------------
  // stage 3: direction differences registered
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst || geom_wr) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2 && s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      s3_border <= s2_border;
      s3_last   <= s2_last;
      s3_dg     <= dg_sum;
      s3_vt     <= vt_sum;
      s3_ad     <= ad_sum;
      s3_hz     <= hz_sum;
      s3_centre <= centre;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: largest absolute difference against threshold times n(2n+1)
  // --------------------------------------------------------------------------
  always_comb begin
    logic [SW-1:0] a_dg, a_vt, a_ad, a_hz;
    logic [KW-1:0] k_eff;
    a_dg = s3_dg[SW-1] ? SW'(-s3_dg) : SW'(s3_dg);
    a_vt = s3_vt[SW-1] ? SW'(-s3_vt) : SW'(s3_vt);
    a_ad = s3_ad[SW-1] ? SW'(-s3_ad) : SW'(s3_ad);
    a_hz = s3_hz[SW-1] ? SW'(-s3_hz) : SW'(s3_hz);
    best = a_dg;
    if (a_vt > best) best = a_vt;
    if (a_ad > best) best = a_ad;
    if (a_hz > best) best = a_hz;
    k_eff = KW'(n_eff) * KW'(2 * n_eff + NW'(1));
    thr_k = TKW'(edge_threshold) * TKW'(k_eff);
    is_edge = CMW'(best) >= CMW'(thr_k);
    if (s3_border)         pix_res = det_pkg::PIX_BLACK;
    else if (is_edge)      pix_res = det_pkg::PIX_WHITE;
    else if (overlay_mode) pix_res = s3_centre;
    else                   pix_res = det_pkg::PIX_BLACK;
  end

  always_ff @(posedge clk) begin
    if (rst || geom_wr) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      pixel_out  <= pix_res;
      frame_last <= s3_last;
    end
  end

  assign out_ch.valid      = v4;
  assign out_ch.pixel_out  = pixel_out;
  assign out_ch.frame_last = frame_last;

endmodule

[sim/directional_edge_threshold_tb.sv]
// ----------------------------------------------------------------------------
// directional_edge_threshold_tb
// streams grey frames through the edge detector under random back-pressure and
// checks every output pixel against a cycle-free scoreboard of the window math
// ----------------------------------------------------------------------------
module directional_edge_threshold_tb;

  localparam int STORE_ROWS  = 7;
  localparam int STORE_COLS  = 1024;
  localparam int SETTLE      = 12;        // pipeline is four deep, leave margin
  localparam int TOTAL_ITEMS = 1900;
  localparam int PXW         = det_pkg::PIXEL_W;
  localparam int CDW         = det_pkg::CFG_DATA_W;

  typedef struct packed {
    logic [det_pkg::PIXEL_W-1:0] pix;
    logic                        last;
  } out_pix_t;

  // how a directed row is checked
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_VALUE} chk_kind_t;
  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    logic [det_pkg::CFG_IDX_W-1:0]  idx;
    logic [det_pkg::CFG_DATA_W-1:0] data;
    logic [det_pkg::ACTION_W-1:0]   act;
    logic [det_pkg::PIXEL_W-1:0]    pix;
    chk_kind_t                      chk;
    out_pix_t                       val;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic                           cfg_we;
  logic [det_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [det_pkg::CFG_DATA_W-1:0] cfg_data;

  det_in_if  in_ch ();
  det_out_if out_ch ();

  directional_edge_threshold uut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // shadow of the block: registers, line store and raster counters
  // --------------------------------------------------------------------------
  logic [det_pkg::HALF_WINDOW_W-1:0]  sh_half;
  logic [det_pkg::THRESHOLD_W-1:0]    sh_thresh;
  logic                               sh_overlay;
  logic [det_pkg::IMAGE_WIDTH_W-1:0]  sh_width;
  logic [det_pkg::IMAGE_HEIGHT_W-1:0] sh_height;
  logic [det_pkg::PIXEL_W-1:0] rows_seen [STORE_ROWS][STORE_COLS];
  int unsigned in_r, in_c, out_r, out_c;

  out_pix_t pending_pixels [$];
  int  errors = 0;
  int  items_sent = 0;
  int  burst_left = 0;

  function automatic int unsigned radius();
    return (sh_half == 0) ? 1 : sh_half;
  endfunction
  function automatic int unsigned cols();
    if (sh_width == 0) return 1;
    return (sh_width > STORE_COLS) ? STORE_COLS : sh_width;
  endfunction
  function automatic int unsigned lines();
    if (sh_height == 0) return 1;
    return (sh_height > 4096) ? 4096 : sh_height;
  endfunction

  // outputs still owed once the whole frame has been read in
  function automatic bit drain_owed();
    return in_r >= lines() && out_r < lines();
  endfunction

  function automatic logic [det_pkg::PIXEL_W-1:0] store_at(int unsigned r, int unsigned c);
    return rows_seen[r % STORE_ROWS][c % STORE_COLS];
  endfunction

  // strongest of the four half-window differences, scaled, against threshold
  function automatic logic [det_pkg::PIXEL_W-1:0] window_result(int unsigned r,
                                                                int unsigned c);
    int unsigned n, w, h, s, v, best;
    int diag, vert, anti, horz;
    n = radius(); w = cols(); h = lines(); s = 2 * n + 1;
    diag = 0; vert = 0; anti = 0; horz = 0;
    if (r < n || r + n >= h || c < n || c + n >= w) return det_pkg::PIX_BLACK;
    for (int unsigned i = 0; i < s; i++) begin
      for (int unsigned j = 0; j < s; j++) begin
        v = store_at(r - n + i, c - n + j);
        if (j > i) diag += v; else if (j < i) diag -= v;
        if (j > n) vert += v; else if (j < n) vert -= v;
        if (i + j > 2 * n) anti += v; else if (i + j < 2 * n) anti -= v;
        if (i < n) horz += v; else if (i > n) horz -= v;
      end
    end
    best = (diag < 0) ? -diag : diag;
    if (((vert < 0) ? -vert : vert) > best) best = (vert < 0) ? -vert : vert;
    if (((anti < 0) ? -anti : anti) > best) best = (anti < 0) ? -anti : anti;
    if (((horz < 0) ? -horz : horz) > best) best = (horz < 0) ? -horz : horz;
    if (best / (n * s) >= sh_thresh) return det_pkg::PIX_WHITE;
    return sh_overlay ? store_at(r, c) : det_pkg::PIX_BLACK;
  endfunction

  function automatic out_pix_t next_output();
    out_pix_t o;
    int unsigned w, h;
    w = cols(); h = lines();
    o.pix  = window_result(out_r, out_c);
    o.last = (out_r == h - 1 && out_c == w - 1);
    out_c++;
    if (out_c >= w) begin
      out_c = 0;
      out_r++;
    end
    if (out_r >= h) begin
      in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    end
    return o;
  endfunction

  // advance the shadow by one accepted item; got tells whether a pixel leaves
  function automatic bit advance_raster(logic [det_pkg::ACTION_W-1:0] act,
                                        logic [det_pkg::PIXEL_W-1:0] pix,
                                        output out_pix_t o);
    int unsigned n, w, h, lag;
    n = radius(); w = cols(); h = lines(); lag = n * w + n;
    if (act == det_pkg::ACT_PIXEL && in_r < h) begin
      rows_seen[in_r % STORE_ROWS][in_c] = pix;
      in_c++;
      if (in_c >= w) begin
        in_c = 0;
        in_r++;
      end
      if ((in_r * w + in_c) - (out_r * w + out_c) > lag) begin
        o = next_output();
        return 1'b1;
      end
      return 1'b0;
    end
    if (drain_owed()) begin
      o = next_output();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------
  task automatic offer_item(logic [det_pkg::ACTION_W-1:0] act,
                            logic [det_pkg::PIXEL_W-1:0] pix,
                            chk_kind_t chk, out_pix_t typed);
    out_pix_t o;
    bit got;
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.pixel_in <= pix;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    got = advance_raster(act, pix, o);
    if (chk == CHK_VALUE) pending_pixels.push_back(typed);
    else if (chk == CHK_MODEL && got) pending_pixels.push_back(o);
    items_sent++;
    // bursts: keep valid up inside a burst, drop it for a random gap after
    if (burst_left == 0) begin
      int gap;
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send(logic [det_pkg::ACTION_W-1:0] act, logic [det_pkg::PIXEL_W-1:0] pix);
    offer_item(act, pix, CHK_MODEL, '0);
  endtask

  // stop offering until every owed pixel is out, then let the pipe settle
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [det_pkg::CFG_IDX_W-1:0] idx,
                           logic [det_pkg::CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      det_pkg::REG_HALF_WINDOW:    sh_half    = data[det_pkg::HALF_WINDOW_W-1:0];
      det_pkg::REG_EDGE_THRESHOLD: sh_thresh  = data[det_pkg::THRESHOLD_W-1:0];
      det_pkg::REG_OVERLAY_MODE:   sh_overlay = data[0];
      det_pkg::REG_IMAGE_WIDTH:    sh_width   = data[det_pkg::IMAGE_WIDTH_W-1:0];
      det_pkg::REG_IMAGE_HEIGHT:   sh_height  = data[det_pkg::IMAGE_HEIGHT_W-1:0];
      default: ;
    endcase
    // geometry writes restart the raster
    if (idx == det_pkg::REG_HALF_WINDOW || idx == det_pkg::REG_IMAGE_WIDTH ||
        idx == det_pkg::REG_IMAGE_HEIGHT) begin
      in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    end
  endtask

  // blocky picture with noise so every direction sees real steps
  function automatic logic [det_pkg::PIXEL_W-1:0] scene_pixel(
      int style, int unsigned r, int unsigned c, int unsigned sr, int unsigned sc,
      logic [det_pkg::PIXEL_W-1:0] lo, logic [det_pkg::PIXEL_W-1:0] hi);
    case (style)
      0: return PXW'($urandom_range(0, 255));
      1: return ((r >= sr) ^ (c >= sc)) ? hi : lo;
      2: return (r + c >= sr + sc) ? hi : lo;
      default: return lo + PXW'($urandom_range(0, 12));
    endcase
  endfunction

  // one frame of well-formed pixels plus a drain, with occasional noise items; may abandon mid-frame
  task automatic stream_frame(bit may_abandon);
    int unsigned w, h, total, stop_at, sr, sc;
    int style;
    logic [det_pkg::PIXEL_W-1:0] lo, hi;
    w = cols(); h = lines(); total = w * h;
    style = $urandom_range(0, 3);
    sr = $urandom_range(0, h); sc = $urandom_range(0, w);
    lo = PXW'($urandom_range(0, 255)); hi = PXW'($urandom_range(0, 255));
    stop_at = (may_abandon && $urandom_range(0, 9) == 0) ? $urandom_range(0, total) : total;
    for (int unsigned k = 0; k < stop_at; k++) begin
      if ($urandom_range(0, 40) == 0)
        send(det_pkg::ACT_FLUSH, PXW'($urandom_range(0, 255)));   // early flush
      send(det_pkg::ACT_PIXEL, scene_pixel(style, k / w, k % w, sr, sc, lo, hi));
    end
    if (stop_at != total) begin
      // abandon mid-frame: a geometry write restarts the raster
      write_reg(det_pkg::REG_HALF_WINDOW, CDW'($urandom_range(0, 3)));
      return;
    end
    // drain; now and then a stray pixel item stands in for a flush
    while (drain_owed())
      send(($urandom_range(0, 5) == 0) ? det_pkg::ACT_PIXEL : det_pkg::ACT_FLUSH,
           PXW'($urandom_range(0, 255)));
    if ($urandom_range(0, 4) == 0)
      send(det_pkg::ACT_FLUSH, PXW'($urandom_range(0, 255)));   // nothing owed
  endtask

  task automatic pick_geometry(int unsigned n, int unsigned w, int unsigned h);
    write_reg(det_pkg::REG_HALF_WINDOW, CDW'(n));
    write_reg(det_pkg::REG_IMAGE_WIDTH, CDW'(w));
    write_reg(det_pkg::REG_IMAGE_HEIGHT, CDW'(h));
    write_reg(det_pkg::REG_EDGE_THRESHOLD,
              CDW'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 60)
                                               : $urandom_range(0, 255)));
    write_reg(det_pkg::REG_OVERLAY_MODE, CDW'($urandom_range(0, 1)));
  endtask

  // --------------------------------------------------------------------------
  // directed table
  // --------------------------------------------------------------------------
  dir_row_t plan [$];

  function automatic void cfg_row(logic [det_pkg::CFG_IDX_W-1:0] idx,
                                  logic [det_pkg::CFG_DATA_W-1:0] data);
    dir_row_t d;
    d = '{ROW_CFG, idx, data, det_pkg::ACT_PIXEL, det_pkg::PIX_BLACK, CHK_NONE, '0};
    plan.push_back(d);
  endfunction

  function automatic void item_row(logic [det_pkg::ACTION_W-1:0] act,
                                   logic [det_pkg::PIXEL_W-1:0] pix,
                                   chk_kind_t chk, out_pix_t val);
    dir_row_t d;
    d = '{ROW_ITEM, '0, '0, act, pix, chk, val};
    plan.push_back(d);
  endfunction

  function automatic void build_plan();
    // reset geometry is 640x480: nothing can come out of a few pixels
    item_row(det_pkg::ACT_PIXEL, 8'h00, CHK_NONE, '0);
    item_row(det_pkg::ACT_PIXEL, 8'hFF, CHK_NONE, '0);
    item_row(det_pkg::ACT_FLUSH, 8'h55, CHK_NONE, '0);     // flush before the frame is in
    // single-pixel image: always border, black, last of frame
    cfg_row(det_pkg::REG_IMAGE_WIDTH, 13'd1);
    cfg_row(det_pkg::REG_IMAGE_HEIGHT, 13'd1);
    item_row(det_pkg::ACT_PIXEL, 8'hAA, CHK_NONE, '0);
    item_row(det_pkg::ACT_FLUSH, 8'h00, CHK_VALUE, '{det_pkg::PIX_BLACK, 1'b1});
    item_row(det_pkg::ACT_FLUSH, 8'hFF, CHK_NONE, '0);     // nothing owed any more
    // 3x3, threshold 0: the lone interior pixel is always an edge
    cfg_row(det_pkg::REG_IMAGE_WIDTH, 13'd3);
    cfg_row(det_pkg::REG_IMAGE_HEIGHT, 13'd3);
    cfg_row(det_pkg::REG_EDGE_THRESHOLD, 13'd0);
    cfg_row(det_pkg::REG_OVERLAY_MODE, 13'd1);
    for (int k = 0; k < 9; k++)
      item_row(det_pkg::ACT_PIXEL, (k == 4) ? 8'h00 : 8'hFF, CHK_MODEL, '0);
    item_row(det_pkg::ACT_PIXEL, 8'h12, CHK_MODEL, '0);   // pixel after frame input acts as flush
    repeat (3) item_row(det_pkg::ACT_FLUSH, 8'h00, CHK_MODEL, '0);
    // threshold 255 with overlay: the centre copy comes out
    cfg_row(det_pkg::REG_EDGE_THRESHOLD, 13'd255);
    for (int k = 0; k < 9; k++) item_row(det_pkg::ACT_PIXEL, 8'(k * 29), CHK_MODEL, '0);
    repeat (4) item_row(det_pkg::ACT_FLUSH, 8'h00, CHK_MODEL, '0);
  endfunction

  // --------------------------------------------------------------------------
  // receiver: runs of steady ready, random stalls, and now and then a long
  // hold-off that fills the pipeline while the sender keeps offering
  // --------------------------------------------------------------------------
  initial begin
    int round;
    out_ch.ready <= 1'b0;
    round = 0;
    @(negedge rst);
    forever begin
      int len;
      round++;
      if (round % 12 == 3) begin
        len = $urandom_range(150, 400);
        repeat (len) begin
          @(posedge clk);
          out_ch.ready <= 1'b0;
        end
      end else if ($urandom_range(0, 2) == 0) begin
        len = $urandom_range(5, 60);
        repeat (len) begin
          @(posedge clk);
          out_ch.ready <= 1'b1;
        end
      end else begin
        len = $urandom_range(5, 60);
        repeat (len) begin
          @(posedge clk);
          out_ch.ready <= ($urandom_range(0, 2) != 0);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // output checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected output pixel %0d last %0b", $time,
                 out_ch.pixel_out, out_ch.frame_last);
        errors++;
      end else begin
        out_pix_t e;
        e = pending_pixels.pop_front();
        if (out_ch.pixel_out !== e.pix) begin
          $display("%0t: pixel_out expected %0d actual %0d", $time, e.pix, out_ch.pixel_out);
          errors++;
        end
        if (out_ch.frame_last !== e.last) begin
          $display("%0t: frame_last expected %0b actual %0b", $time, e.last,
                   out_ch.frame_last);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.action   <= det_pkg::ACT_PIXEL;
    in_ch.pixel_in <= '0;
    sh_half    = det_pkg::RST_HALF_WINDOW;
    sh_thresh  = det_pkg::RST_EDGE_THRESHOLD;
    sh_overlay = det_pkg::RST_OVERLAY_MODE;
    sh_width   = det_pkg::RST_IMAGE_WIDTH;
    sh_height  = det_pkg::RST_IMAGE_HEIGHT;
    in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    build_plan();
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_reg(plan[i].idx, plan[i].data);
      else offer_item(plan[i].act, plan[i].pix, plan[i].chk, plan[i].val);
    end

    // extremes of geometry: largest radius, zero width, zero height
    pick_geometry(3, 9, 8);
    stream_frame(1'b0);
    pick_geometry(0, 0, 5);
    stream_frame(1'b0);
    pick_geometry(2, 7, 0);
    stream_frame(1'b0);

    while (items_sent < TOTAL_ITEMS) begin
      pick_geometry($urandom_range(0, 3), $urandom_range(1, 24), $urandom_range(1, 16));
      stream_frame(1'b1);
    end

    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // run-away guard
  initial begin
    #24000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
